FILE: hw/rtl/grc_pkg.sv
`timescale 1ns / 1ps

package grc_pkg;

   // Field widths
   localparam int POS_W   = 17;
   localparam int ANG_W   = 10;
   localparam int DIST_W  = 18;
   localparam int HGT_W   = 9;
   localparam int TOP_W   = 8;
   localparam int MAP_W   = 64;
   localparam int IDX_W   = 6;

   // Internal datapath widths
   localparam int COORD_W = 34;   // signed walk coordinates, Q8
   localparam int TRIG_W  = 18;   // signed Q1.14 sine / cosine and CORDIC angle
   localparam int MUL_W   = 18;   // shared multiplier operand width
   localparam int PROD_W  = 36;
   localparam int DIV_NW  = 30;   // divider dividend / quotient width
   localparam int DIV_DW  = 18;   // divider divisor width
   localparam int DIV_CW  = 5;
   localparam int SQ_W    = 36;   // root radicand width
   localparam int ROOT_W  = 18;
   localparam int SQ_CW   = 5;

   // Geometry: 64-pixel tiles in Q8 are 2^14 units
   localparam int TILE_SHIFT = 14;
   localparam int TILE_Q     = 16384;
   localparam int CELL_W     = 3;

   // Angle codes, 1024 steps per turn
   localparam logic [ANG_W-1:0] ANG_ZERO    = 10'd0;
   localparam logic [ANG_W-1:0] ANG_QUARTER = 10'd256;
   localparam logic [ANG_W-1:0] ANG_HALF    = 10'd512;
   localparam logic [ANG_W-1:0] ANG_3QUART  = 10'd768;

   // CORDIC
   localparam int CORDIC_N = 14;
   localparam logic signed [TRIG_W-1:0] CORDIC_K  = 18'sd9949;
   localparam logic signed [TRIG_W-1:0] Z_HALF    = 18'sd32768;
   localparam logic signed [TRIG_W-1:0] Z_TURN    = 18'sd65536;

   // Screen and saturation constants
   localparam logic [HGT_W-1:0]  SCREEN_H   = 9'd320;
   localparam logic [TOP_W-1:0]  SCREEN_MID = 8'd160;
   localparam logic [DIST_W-1:0] DIST_MAX   = 18'd262143;
   localparam logic [DIV_NW-1:0] HEIGHT_NUM = 30'd5242880;   // 64 * 320 * 256

   localparam logic [MAP_W-1:0]  MAP_RESET  = 64'hFF81_A181_8585_85FF;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [ANG_W-1:0] ray_angle;
      logic [ANG_W-1:0] view_angle;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  hit_x;
      logic [POS_W-1:0]  hit_y;
      logic              hit_vertical;
      logic              wall_found;
      logic [DIST_W-1:0] corrected_distance;
      logic [HGT_W-1:0]  line_height;
      logic [TOP_W-1:0]  line_top;
   } rsp_type;

   // arctan(2^-i) in 1/65536 of a turn
   function automatic logic signed [TRIG_W-1:0] atan_turn(input logic [3:0] i);
      logic signed [TRIG_W-1:0] r;
      case (i)
         4'd0:    r = 18'sd8192;
         4'd1:    r = 18'sd4836;
         4'd2:    r = 18'sd2555;
         4'd3:    r = 18'sd1297;
         4'd4:    r = 18'sd651;
         4'd5:    r = 18'sd326;
         4'd6:    r = 18'sd163;
         4'd7:    r = 18'sd81;
         4'd8:    r = 18'sd41;
         4'd9:    r = 18'sd20;
         4'd10:   r = 18'sd10;
         4'd11:   r = 18'sd5;
         4'd12:   r = 18'sd3;
         4'd13:   r = 18'sd1;
         default: r = 18'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/grc_cordic.sv
`timescale 1ns / 1ps

// Rotation CORDIC, one micro-rotation per cycle
module grc_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [grc_pkg::ANG_W-1:0]           angle,
   output logic                                done,
   output logic signed [grc_pkg::TRIG_W-1:0]   cos_out,
   output logic signed [grc_pkg::TRIG_W-1:0]   sin_out
);

   localparam logic [3:0] LAST_ITER = 4'(grc_pkg::CORDIC_N - 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic                              flip_ff;
   logic [3:0]                        iter_ff;
   logic signed [grc_pkg::TRIG_W-1:0] x_ff, y_ff, z_ff;
   logic signed [grc_pkg::TRIG_W-1:0] cos_ff, sin_ff;

   logic [15:0]                       turn;
   logic signed [grc_pkg::TRIG_W-1:0] z_turn, z_init;
   logic signed [grc_pkg::TRIG_W-1:0] x_nx, y_nx, z_nx;

   // Map the angle into [-1/4, 1/4] turn, remembering a half-turn flip
   always_comb begin
      turn   = {angle, 6'b0};
      z_turn = grc_pkg::TRIG_W'(turn);
      if (angle[9] ^ angle[8]) begin
         z_init = z_turn - grc_pkg::Z_HALF;
      end else if (angle[9]) begin
         z_init = z_turn - grc_pkg::Z_TURN;
      end else begin
         z_init = z_turn;
      end
   end

   // One micro-rotation; arithmetic shifts floor
   always_comb begin
      if (!z_ff[grc_pkg::TRIG_W-1]) begin
         x_nx = x_ff - (y_ff >>> iter_ff);
         y_nx = y_ff + (x_ff >>> iter_ff);
         z_nx = z_ff - grc_pkg::atan_turn(iter_ff);
      end else begin
         x_nx = x_ff + (y_ff >>> iter_ff);
         y_nx = y_ff - (x_ff >>> iter_ff);
         z_nx = z_ff + grc_pkg::atan_turn(iter_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
            flip_ff <= angle[9] ^ angle[8];
            x_ff    <= grc_pkg::CORDIC_K;
            y_ff    <= '0;
            z_ff    <= z_init;
         end else if (busy_ff) begin
            x_ff    <= x_nx;
            y_ff    <= y_nx;
            z_ff    <= z_nx;
            iter_ff <= iter_ff + 4'd1;
            if (iter_ff == LAST_ITER) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               cos_ff  <= flip_ff ? -x_nx : x_nx;
               sin_ff  <= flip_ff ? -y_nx : y_nx;
            end
         end
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

FILE: hw/rtl/grc_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle
module grc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [grc_pkg::DIV_NW-1:0]    dividend,
   input  logic [grc_pkg::DIV_DW-1:0]    divisor,
   output logic                          done,
   output logic [grc_pkg::DIV_NW-1:0]    quotient
);

   localparam logic [grc_pkg::DIV_CW-1:0] LAST_BIT = grc_pkg::DIV_CW'(grc_pkg::DIV_NW - 1);

   logic                           busy_ff;
   logic                           done_ff;
   logic [grc_pkg::DIV_CW-1:0]     cnt_ff;
   logic [grc_pkg::DIV_DW-1:0]     den_ff;
   logic [grc_pkg::DIV_DW-1:0]     rem_ff;
   logic [grc_pkg::DIV_NW-1:0]     quo_ff;

   logic [grc_pkg::DIV_DW:0]       rem_sh;
   logic [grc_pkg::DIV_DW:0]       trial;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      rem_sh = {rem_ff, quo_ff[grc_pkg::DIV_NW-1]};
      trial  = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            den_ff  <= divisor;
            rem_ff  <= '0;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            if (!trial[grc_pkg::DIV_DW]) begin
               rem_ff <= trial[grc_pkg::DIV_DW-1:0];
               quo_ff <= {quo_ff[grc_pkg::DIV_NW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[grc_pkg::DIV_DW-1:0];
               quo_ff <= {quo_ff[grc_pkg::DIV_NW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIT) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/grc_isqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one result bit per cycle
module grc_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [grc_pkg::SQ_W-1:0]     radicand,
   output logic                         done,
   output logic [grc_pkg::ROOT_W-1:0]   root
);

   localparam logic [grc_pkg::SQ_CW-1:0] LAST_BIT = grc_pkg::SQ_CW'(grc_pkg::ROOT_W - 1);
   localparam logic [grc_pkg::SQ_W-1:0]  B_INIT   =
      grc_pkg::SQ_W'(1) << (2 * grc_pkg::ROOT_W - 2);

   logic                        busy_ff;
   logic                        done_ff;
   logic [grc_pkg::SQ_CW-1:0]   cnt_ff;
   logic [grc_pkg::SQ_W-1:0]    v_ff, r_ff, b_ff;

   logic [grc_pkg::SQ_W-1:0]    rb;
   logic                        ge;

   always_comb begin
      rb = r_ff + b_ff;
      ge = (v_ff >= rb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            v_ff    <= radicand;
            r_ff    <= '0;
            b_ff    <= B_INIT;
         end else if (busy_ff) begin
            if (ge) begin
               v_ff <= v_ff - rb;
               r_ff <= (r_ff >> 1) + b_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            b_ff   <= b_ff >> 2;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIT) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = r_ff[grc_pkg::ROOT_W-1:0];

endmodule

FILE: hw/rtl/grid_ray_caster_unit.sv
`timescale 1ns / 1ps

// Grid ray caster. Each request casts one ray over the tile map held in the
// map_ff register and returns the nearer wall hit, its fisheye-corrected
// distance and the wall slice height and top row. Requests are taken one at a
// time: req_ready is high only while the unit is idle. A request runs the ray
// CORDIC, then per grid pass two serial divisions, up to MAX_STEPS walk steps
// and a square root, then the view CORDIC and one more division for the height.
// The 30-step divider, shared by all five divisions, takes most of that time.
// A finished result waits in the output register while the next request is
// taken. The map register may be written at any time through csr_valid.
module grid_ray_caster_unit #(
   parameter int MAP_DIM   = 8,
   parameter int MAX_STEPS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  grc_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output grc_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [grc_pkg::MAP_W-1:0]    csr_data
);

   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_STEPS - 1);
   localparam logic signed [grc_pkg::COORD_W-1:0] MAP_LIMIT =
      grc_pkg::COORD_W'(MAP_DIM * grc_pkg::TILE_Q);
   localparam logic signed [grc_pkg::COORD_W-1:0] TILE_C =
      grc_pkg::COORD_W'(grc_pkg::TILE_Q);
   localparam logic [grc_pkg::IDX_W-1:0] MAP_DIM_C = grc_pkg::IDX_W'(MAP_DIM);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RAY_TRIG, ST_SETUP, ST_MUL, ST_DIV_OFS, ST_DIV_STEP, ST_WALK,
      ST_SQ_X, ST_SQ_Y, ST_ROOT_GO, ST_ROOT, ST_NEXT, ST_PICK, ST_VIEW_TRIG,
      ST_SCALE, ST_OUT
   } state_type;

   // ------------------------------------------------------------------
   // Registers
   state_type                                state_ff;
   grc_pkg::req_type                         req_ff;
   logic [grc_pkg::MAP_W-1:0]                map_ff;
   logic signed [grc_pkg::TRIG_W-1:0]        cr_ff, sr_ff;
   logic                                     pass_ff;     // 0 horizontal, 1 vertical
   logic                                     neg_ff;
   logic                                     height_ff;   // divider busy on height
   logic signed [grc_pkg::COORD_W-1:0]       cur_x_ff, cur_y_ff, stx_ff, sty_ff;
   logic [STEP_W-1:0]                        cnt_ff;
   logic [grc_pkg::PROD_W-1:0]               mul_ff;
   logic [grc_pkg::SQ_W-1:0]                 sq_ff;
   logic                                     hit_h_ff, hit_v_ff;
   logic [grc_pkg::ROOT_W-1:0]               dh_ff, dv_ff, d_ff;
   logic [grc_pkg::POS_W-1:0]                hhx_ff, hhy_ff, vhx_ff, vhy_ff;
   logic [grc_pkg::POS_W-1:0]                ox_ff, oy_ff;
   logic                                     vert_ff, found_ff;
   logic [grc_pkg::DIST_W-1:0]               cd_ff;
   logic [grc_pkg::HGT_W-1:0]                h_ff;
   grc_pkg::rsp_type                         rsp_ff;
   logic                                     rsp_valid_ff;

   // ------------------------------------------------------------------
   // Shared unit hookups
   logic                                     cordic_start, cordic_done;
   logic [grc_pkg::ANG_W-1:0]                cordic_angle;
   logic signed [grc_pkg::TRIG_W-1:0]        cordic_cos, cordic_sin;
   logic                                     div_start, div_done;
   logic [grc_pkg::DIV_NW-1:0]               div_num, div_quo;
   logic [grc_pkg::DIV_DW-1:0]               div_den;
   logic                                     sq_start, sq_done;
   logic [grc_pkg::ROOT_W-1:0]               sq_root;

   grc_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin)
   );

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   grc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   // ------------------------------------------------------------------
   // Pass view: the pass crosses lines of the primary axis
   logic [grc_pkg::POS_W-1:0]                prim_pos, sec_pos;
   logic signed [grc_pkg::TRIG_W-1:0]        num_t, den_t;
   logic [grc_pkg::TRIG_W-1:0]               num_mag, den_mag;
   logic                                     pass_en, dir_neg;
   logic signed [grc_pkg::COORD_W-1:0]       base_c, prim_new, prim_cur, diff_c;
   logic signed [grc_pkg::COORD_W-1:0]       prim_pos_c, sec_pos_c, q_c, qs_c;
   logic signed [grc_pkg::COORD_W-1:0]       dx_c, dy_c, mag_c;
   logic [grc_pkg::ANG_W-1:0]                ang;

   always_comb begin
      ang      = req_ff.ray_angle;
      prim_pos = pass_ff ? req_ff.pos_x : req_ff.pos_y;
      sec_pos  = pass_ff ? req_ff.pos_y : req_ff.pos_x;
      num_t    = pass_ff ? sr_ff : cr_ff;
      den_t    = pass_ff ? cr_ff : sr_ff;
      num_mag  = num_t[grc_pkg::TRIG_W-1] ? grc_pkg::TRIG_W'(-num_t) : num_t;
      den_mag  = den_t[grc_pkg::TRIG_W-1] ? grc_pkg::TRIG_W'(-den_t) : den_t;
      if (!pass_ff) begin
         pass_en = (ang != grc_pkg::ANG_ZERO) && (ang != grc_pkg::ANG_HALF) && (sr_ff != '0);
         dir_neg = (ang > grc_pkg::ANG_HALF);
      end else begin
         pass_en = (ang != grc_pkg::ANG_QUARTER) && (ang != grc_pkg::ANG_3QUART)
                   && (cr_ff != '0);
         dir_neg = (ang > grc_pkg::ANG_QUARTER) && (ang < grc_pkg::ANG_3QUART);
      end
      prim_pos_c = grc_pkg::COORD_W'(prim_pos);
      sec_pos_c  = grc_pkg::COORD_W'(sec_pos);
      base_c     = grc_pkg::COORD_W'({prim_pos[grc_pkg::POS_W-1:grc_pkg::TILE_SHIFT],
                                      {grc_pkg::TILE_SHIFT{1'b0}}});
      prim_new   = dir_neg ? base_c - 1 : base_c + TILE_C;
      prim_cur   = pass_ff ? cur_x_ff : cur_y_ff;
      diff_c     = prim_cur - prim_pos_c;
      q_c        = grc_pkg::COORD_W'(div_quo);
      qs_c       = neg_ff ? -q_c : q_c;
      dx_c       = cur_x_ff - grc_pkg::COORD_W'(req_ff.pos_x);
      dy_c       = cur_y_ff - grc_pkg::COORD_W'(req_ff.pos_y);
   end

   // ------------------------------------------------------------------
   // Shared multiplier
   logic [grc_pkg::MUL_W-1:0]                mul_a, mul_b;
   logic [grc_pkg::PROD_W-1:0]               prod;

   always_comb begin
      mag_c = '0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL: begin
            mag_c = diff_c[grc_pkg::COORD_W-1] ? -diff_c : diff_c;
            mul_a = mag_c[grc_pkg::MUL_W-1:0];
            mul_b = num_mag;
         end
         ST_SQ_X: begin
            mag_c = dx_c[grc_pkg::COORD_W-1] ? -dx_c : dx_c;
            mul_a = mag_c[grc_pkg::MUL_W-1:0];
            mul_b = mag_c[grc_pkg::MUL_W-1:0];
         end
         ST_SQ_Y: begin
            mag_c = dy_c[grc_pkg::COORD_W-1] ? -dy_c : dy_c;
            mul_a = mag_c[grc_pkg::MUL_W-1:0];
            mul_b = mag_c[grc_pkg::MUL_W-1:0];
         end
         ST_VIEW_TRIG: begin
            mul_a = d_ff;
            mul_b = cordic_cos;
         end
         default: begin
            mul_a = '0;
         end
      endcase
      prod = grc_pkg::PROD_W'(mul_a) * grc_pkg::PROD_W'(mul_b);
   end

   // ------------------------------------------------------------------
   // Map cell lookup at the current walk position
   logic                                     in_map, wall;
   logic [grc_pkg::CELL_W-1:0]               mx, my;
   logic [grc_pkg::IDX_W-1:0]                cell_idx;

   always_comb begin
      mx       = cur_x_ff[grc_pkg::TILE_SHIFT+grc_pkg::CELL_W-1:grc_pkg::TILE_SHIFT];
      my       = cur_y_ff[grc_pkg::TILE_SHIFT+grc_pkg::CELL_W-1:grc_pkg::TILE_SHIFT];
      in_map   = !cur_x_ff[grc_pkg::COORD_W-1] && !cur_y_ff[grc_pkg::COORD_W-1]
                 && (cur_x_ff < MAP_LIMIT) && (cur_y_ff < MAP_LIMIT);
      cell_idx = grc_pkg::IDX_W'(my) * MAP_DIM_C + grc_pkg::IDX_W'(mx);
      wall     = in_map && map_ff[cell_idx];
   end

   // ------------------------------------------------------------------
   // Hit choice, distance scaling and height clamp
   logic                                     sel_v, found_c;
   logic [grc_pkg::PROD_W-grc_pkg::TILE_SHIFT-1:0] cd_wide;
   logic [grc_pkg::DIST_W-1:0]               cd_c;
   logic [grc_pkg::HGT_W-1:0]                h_c;

   always_comb begin
      sel_v   = hit_v_ff && (!hit_h_ff || (dv_ff < dh_ff));
      found_c = hit_v_ff || hit_h_ff;
      cd_wide = mul_ff[grc_pkg::PROD_W-1:grc_pkg::TILE_SHIFT];
      cd_c    = (cd_wide > (grc_pkg::PROD_W-grc_pkg::TILE_SHIFT)'(grc_pkg::DIST_MAX))
                ? grc_pkg::DIST_MAX : cd_wide[grc_pkg::DIST_W-1:0];
      h_c     = (div_quo > grc_pkg::DIV_NW'(grc_pkg::SCREEN_H)) ? grc_pkg::SCREEN_H
                : div_quo[grc_pkg::HGT_W-1:0];
   end

   // ------------------------------------------------------------------
   // Unit starts
   always_comb begin
      cordic_start = ((state_ff == ST_IDLE) && req_valid)
                     || ((state_ff == ST_PICK) && found_c);
      cordic_angle = (state_ff == ST_IDLE) ? req_data.ray_angle
                     : req_ff.view_angle - req_ff.ray_angle;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = den_mag;
      case (state_ff)
         ST_MUL: begin
            div_start = 1'b1;
            div_num   = prod[grc_pkg::DIV_NW-1:0];
         end
         ST_DIV_OFS: begin
            div_start = div_done;
            div_num   = grc_pkg::DIV_NW'(num_mag) << grc_pkg::TILE_SHIFT;
         end
         ST_SCALE: begin
            div_start = (cd_c != '0);
            div_num   = grc_pkg::HEIGHT_NUM;
            div_den   = cd_c;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
      sq_start = (state_ff == ST_ROOT_GO);
   end

   // ------------------------------------------------------------------
   // Map register
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= grc_pkg::MAP_RESET;
      end else if (csr_valid) begin
         map_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
         hit_h_ff     <= 1'b0;
         hit_v_ff     <= 1'b0;
         height_ff    <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         // output register: set on load, cleared once taken
         if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  pass_ff   <= 1'b0;
                  hit_h_ff  <= 1'b0;
                  hit_v_ff  <= 1'b0;
                  height_ff <= 1'b0;
                  state_ff  <= ST_RAY_TRIG;
               end
            end
            ST_RAY_TRIG: begin
               if (cordic_done) begin
                  cr_ff    <= cordic_cos;
                  sr_ff    <= cordic_sin;
                  state_ff <= ST_SETUP;
               end
            end
            // first grid line crossed and its primary-axis step
            ST_SETUP: begin
               if (pass_en) begin
                  neg_ff <= dir_neg ^ num_t[grc_pkg::TRIG_W-1] ^ den_t[grc_pkg::TRIG_W-1];
                  if (pass_ff) begin
                     cur_x_ff <= prim_new;
                     stx_ff   <= dir_neg ? -TILE_C : TILE_C;
                  end else begin
                     cur_y_ff <= prim_new;
                     sty_ff   <= dir_neg ? -TILE_C : TILE_C;
                  end
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_MUL: begin
               state_ff <= ST_DIV_OFS;
            end
            ST_DIV_OFS: begin
               if (div_done) begin
                  if (pass_ff) begin
                     cur_y_ff <= sec_pos_c + qs_c;
                  end else begin
                     cur_x_ff <= sec_pos_c + qs_c;
                  end
                  state_ff <= ST_DIV_STEP;
               end
            end
            ST_DIV_STEP: begin
               if (div_done) begin
                  if (pass_ff) begin
                     sty_ff <= qs_c;
                  end else begin
                     stx_ff <= qs_c;
                  end
                  cnt_ff   <= '0;
                  state_ff <= ST_WALK;
               end
            end
            // one grid crossing per cycle
            ST_WALK: begin
               if (wall) begin
                  state_ff <= ST_SQ_X;
               end else if (cnt_ff == LAST_STEP) begin
                  state_ff <= ST_NEXT;
               end else begin
                  cur_x_ff <= cur_x_ff + stx_ff;
                  cur_y_ff <= cur_y_ff + sty_ff;
                  cnt_ff   <= cnt_ff + 1'b1;
               end
            end
            ST_SQ_X: begin
               mul_ff   <= prod;
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               sq_ff    <= mul_ff + prod;
               state_ff <= ST_ROOT_GO;
            end
            ST_ROOT_GO: begin
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (sq_done) begin
                  if (pass_ff) begin
                     hit_v_ff <= 1'b1;
                     dv_ff    <= sq_root;
                     vhx_ff   <= cur_x_ff[grc_pkg::POS_W-1:0];
                     vhy_ff   <= cur_y_ff[grc_pkg::POS_W-1:0];
                  end else begin
                     hit_h_ff <= 1'b1;
                     dh_ff    <= sq_root;
                     hhx_ff   <= cur_x_ff[grc_pkg::POS_W-1:0];
                     hhy_ff   <= cur_y_ff[grc_pkg::POS_W-1:0];
                  end
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               if (!pass_ff) begin
                  pass_ff  <= 1'b1;
                  state_ff <= ST_SETUP;
               end else begin
                  state_ff <= ST_PICK;
               end
            end
            // nearer hit wins, a tie goes to the horizontal one
            ST_PICK: begin
               found_ff <= found_c;
               vert_ff  <= sel_v;
               if (sel_v) begin
                  ox_ff <= vhx_ff;
                  oy_ff <= vhy_ff;
                  d_ff  <= dv_ff;
               end else if (hit_h_ff) begin
                  ox_ff <= hhx_ff;
                  oy_ff <= hhy_ff;
                  d_ff  <= dh_ff;
               end else begin
                  ox_ff <= req_ff.pos_x;
                  oy_ff <= req_ff.pos_y;
               end
               if (found_c) begin
                  state_ff <= ST_VIEW_TRIG;
               end else begin
                  cd_ff    <= grc_pkg::DIST_MAX;
                  h_ff     <= '0;
                  state_ff <= ST_OUT;
               end
            end
            // fisheye correction; a wall behind the viewer gives full height
            ST_VIEW_TRIG: begin
               if (height_ff) begin
                  if (div_done) begin
                     h_ff      <= h_c;
                     height_ff <= 1'b0;
                     state_ff  <= ST_OUT;
                  end
               end else if (cordic_done) begin
                  if (cordic_cos[grc_pkg::TRIG_W-1] || (cordic_cos == '0)) begin
                     cd_ff    <= '0;
                     h_ff     <= grc_pkg::SCREEN_H;
                     state_ff <= ST_OUT;
                  end else begin
                     mul_ff   <= prod;
                     state_ff <= ST_SCALE;
                  end
               end
            end
            ST_SCALE: begin
               cd_ff <= cd_c;
               if (cd_c == '0) begin
                  h_ff     <= grc_pkg::SCREEN_H;
                  state_ff <= ST_OUT;
               end else begin
                  height_ff <= 1'b1;
                  state_ff  <= ST_VIEW_TRIG;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.hit_x              <= ox_ff;
                  rsp_ff.hit_y              <= oy_ff;
                  rsp_ff.hit_vertical       <= vert_ff;
                  rsp_ff.wall_found         <= found_ff;
                  rsp_ff.corrected_distance <= cd_ff;
                  rsp_ff.line_height        <= h_ff;
                  rsp_ff.line_top           <= grc_pkg::SCREEN_MID
                                               - grc_pkg::TOP_W'(h_ff >> 1);
                  state_ff                  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------
   // Checks
   a_height_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.line_height <= grc_pkg::SCREEN_H)
      else $error("line height above screen height");

   a_vert_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_vertical |-> rsp_data.wall_found)
      else $error("vertical hit flagged without a wall");

   a_miss_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.wall_found |->
         rsp_data.line_height == '0 && rsp_data.corrected_distance == grc_pkg::DIST_MAX)
      else $error("miss result carries a distance or height");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> cnt_ff <= LAST_STEP)
      else $error("walk went past the step limit");

   a_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && !rsp_ready |=> state_ff == ST_OUT)
      else $error("result dropped while output held");

endmodule

FILE: tb/tb_grid_ray_caster_unit.sv
`timescale 1ns / 1ps

module tb_grid_ray_caster_unit;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   grc_pkg::req_type             req_data;
   logic                         rsp_valid;
   logic                         rsp_ready;
   grc_pkg::rsp_type             rsp_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [grc_pkg::MAP_W-1:0]    csr_data;

   grid_ray_caster_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   localparam int  CYCLE_LIMIT = 2_000_000;
   localparam int  RANDOM_RAYS = 1900;

   // arctan(2^-i) in 1/65536 turn, for the local CORDIC
   localparam int ATAN_TAB [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                    5, 3, 1};

   logic [grc_pkg::MAP_W-1:0] map_copy;
   grc_pkg::rsp_type          pending_rsp[$];
   int                        errors;
   int                        cycles;
   int                        rays_sent;
   int                        walls_seen;
   int                        vertical_seen;
   int                        maps_written;
   bit                        stimulus_done;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_rsp.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Q1.14 cosine and sine of an angle in 1024 steps per turn
   function automatic void trig(input int ang, output int c, output int s);
      int t, z, x, y, nx, i;
      bit flip;
      t = (ang % 1024) * 64;
      flip = (t >= 16384 && t < 49152);
      if (flip) z = t - 32768;
      else if (t >= 49152) z = t - 65536;
      else z = t;
      x = 9949;
      y = 0;
      for (i = 0; i < 14; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TAB[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TAB[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic bit is_wall_cell(input longint x, input longint y,
                                       input logic [grc_pkg::MAP_W-1:0] walls);
      longint mx, my;
      if (x < 0 || y < 0) return 1'b0;
      mx = x / grc_pkg::TILE_Q;
      my = y / grc_pkg::TILE_Q;
      if (mx >= 8 || my >= 8) return 1'b0;
      return walls[my * 8 + mx];
   endfunction

   // step along grid-line crossings until a wall or the step limit
   function automatic bit march(inout longint x, inout longint y, input longint sx,
                                input longint sy, input logic [grc_pkg::MAP_W-1:0] walls);
      int i;
      for (i = 0; i < 8; i++) begin
         if (is_wall_cell(x, y, walls)) return 1'b1;
         x = x + sx;
         y = y + sy;
      end
      return 1'b0;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned r, b;
      int i;
      r = 0;
      b = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned span(input longint px, input longint py,
                                            input longint x, input longint y);
      longint dx, dy;
      longint unsigned ux, uy;
      dx = x - px;
      dy = y - py;
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      return int_root(ux * ux + uy * uy);
   endfunction

   function automatic grc_pkg::rsp_type cast_ray(input grc_pkg::req_type r,
                                                 input logic [grc_pkg::MAP_W-1:0] walls);
      grc_pkg::rsp_type o;
      longint px, py, hx, hy, vx, vy, ox, oy, base, sx, sy;
      longint unsigned dh, dv, d, cd, h;
      int a, va, cr, sr, cv, sv;
      bit hit_h, hit_v, vert, found;
      px = longint'(r.pos_x);
      py = longint'(r.pos_y);
      a  = int'(r.ray_angle);
      va = int'(r.view_angle);
      hit_h = 0; hit_v = 0; vert = 0; found = 1;
      dh = 0; dv = 0; hx = 0; hy = 0; vx = 0; vy = 0;
      trig(a, cr, sr);

      // horizontal grid lines, skipped along the x axis
      if (a != 0 && a != 512 && sr != 0) begin
         base = (py / grc_pkg::TILE_Q) * grc_pkg::TILE_Q;
         if (a > 512) begin
            hy = base - 1;
            sy = -grc_pkg::TILE_Q;
         end else begin
            hy = base + grc_pkg::TILE_Q;
            sy = grc_pkg::TILE_Q;
         end
         hx = px + ((hy - py) * longint'(cr)) / longint'(sr);
         sx = (sy * longint'(cr)) / longint'(sr);
         hit_h = march(hx, hy, sx, sy, walls);
         if (hit_h) dh = span(px, py, hx, hy);
      end

      // vertical grid lines, skipped along the y axis
      if (a != 256 && a != 768 && cr != 0) begin
         base = (px / grc_pkg::TILE_Q) * grc_pkg::TILE_Q;
         if (a > 256 && a < 768) begin
            vx = base - 1;
            sx = -grc_pkg::TILE_Q;
         end else begin
            vx = base + grc_pkg::TILE_Q;
            sx = grc_pkg::TILE_Q;
         end
         vy = py + ((vx - px) * longint'(sr)) / longint'(cr);
         sy = (sx * longint'(sr)) / longint'(cr);
         hit_v = march(vx, vy, sx, sy, walls);
         if (hit_v) dv = span(px, py, vx, vy);
      end

      // nearer hit, a tie goes to the horizontal one
      if (hit_v && (!hit_h || dv < dh)) begin
         vert = 1; ox = vx; oy = vy; d = dv;
      end else if (hit_h) begin
         ox = hx; oy = hy; d = dh;
      end else begin
         found = 0; ox = px; oy = py; d = 0;
      end

      if (found) begin
         trig((va + 1024 - a) % 1024, cv, sv);
         if (cv <= 0) cd = 0;
         else cd = (d * longint'(cv)) >> 14;
         if (cd > 262143) cd = 262143;
         h = (cd != 0) ? 64'd5242880 / cd : 64'd320;
         if (h > 320) h = 320;
      end else begin
         cd = 262143;
         h = 0;
      end

      if (ox < 0) ox = 0;
      if (oy < 0) oy = 0;
      if (ox > 131071) ox = 131071;
      if (oy > 131071) oy = 131071;

      o.hit_x              = ox[grc_pkg::POS_W-1:0];
      o.hit_y              = oy[grc_pkg::POS_W-1:0];
      o.hit_vertical       = vert;
      o.wall_found         = found;
      o.corrected_distance = cd[grc_pkg::DIST_W-1:0];
      o.line_height        = h[grc_pkg::HGT_W-1:0];
      o.line_top           = 8'(160 - h / 2);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      grc_pkg::rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result transaction with nothing pending");
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            check_field("hit_x", w.hit_x, rsp_data.hit_x);
            check_field("hit_y", w.hit_y, rsp_data.hit_y);
            check_field("hit_vertical", w.hit_vertical, rsp_data.hit_vertical);
            check_field("wall_found", w.wall_found, rsp_data.wall_found);
            check_field("corrected_distance", w.corrected_distance,
                        rsp_data.corrected_distance);
            check_field("line_height", w.line_height, rsp_data.line_height);
            check_field("line_top", w.line_top, rsp_data.line_top);
         end
      end
   end

   // Receiver stalls in one of four randomly chosen modes
   always @(posedge clock) begin
      int mode;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (cycles % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ((cycles % 16) < 11);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // one ray transaction; valid is left high for a following item
   task automatic send_ray(input grc_pkg::req_type r);
      grc_pkg::rsp_type w;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      w = cast_ray(r, map_copy);
      pending_rsp.push_back(w);
      rays_sent++;
      if (w.wall_found) walls_seen++;
      if (w.hit_vertical) vertical_seen++;
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_map(input logic [grc_pkg::MAP_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      map_copy = v;
      maps_written++;
   endtask

   function automatic grc_pkg::req_type ray(input int x, input int y, input int a,
                                            input int v);
      grc_pkg::req_type r;
      r.pos_x      = x[grc_pkg::POS_W-1:0];
      r.pos_y      = y[grc_pkg::POS_W-1:0];
      r.ray_angle  = a[grc_pkg::ANG_W-1:0];
      r.view_angle = v[grc_pkg::ANG_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // bordered reset map, all axis angles and near-axis angles
   task automatic test_axis_angles;
      int c;
      c = 96 * 256;
      send_ray(ray(c, c, grc_pkg::ANG_ZERO, grc_pkg::ANG_ZERO));
      send_ray(ray(c, c, grc_pkg::ANG_QUARTER, grc_pkg::ANG_QUARTER));
      send_ray(ray(c, c, grc_pkg::ANG_HALF, grc_pkg::ANG_HALF));
      send_ray(ray(c, c, grc_pkg::ANG_3QUART, grc_pkg::ANG_3QUART));
      send_ray(ray(c, c, 1, 0));
      send_ray(ray(c, c, 1023, 1023));
      send_ray(ray(c, c, 255, 257));
      send_ray(ray(c, c, 513, 600));
      pause_sender(3);
   endtask

   // viewer on a grid line, and at the field extremes
   task automatic test_edges;
      send_ray(ray(3 * grc_pkg::TILE_Q, 3 * grc_pkg::TILE_Q, 700, 700));
      send_ray(ray(3 * grc_pkg::TILE_Q, 3 * grc_pkg::TILE_Q, 300, 300));
      send_ray(ray(0, 0, 128, 128));
      send_ray(ray(131071, 131071, 640, 640));
      send_ray(ray(131071, 0, 384, 384));
      send_ray(ray(0, 131071, 896, 896));
      pause_sender(2);
   endtask

   // wall behind the viewer (view opposite or square to the ray), and a view that wraps past zero
   task automatic test_behind_viewer;
      send_ray(ray(200 * 256, 150 * 256, 100, 612));
      send_ray(ray(200 * 256, 150 * 256, 100, 356));
      send_ray(ray(200 * 256, 150 * 256, 900, 644));
      send_ray(ray(200 * 256, 150 * 256, 10, 1020));
   endtask

   // empty map (no wall) and full map (viewer inside a wall, in cells 0 and 63)
   task automatic test_map_extremes;
      write_map('0);
      send_ray(ray(100 * 256, 100 * 256, 37, 37));
      send_ray(ray(300 * 256, 20 * 256, 800, 790));
      write_map('1);
      send_ray(ray(10 * 256, 10 * 256, 37, 37));
      send_ray(ray(0, 0, 0, 0));
      send_ray(ray(450 * 256, 450 * 256, 600, 600));
   endtask

   function automatic int pick_angle;
      case ($urandom_range(0, 9))
         0:       return 256 * $urandom_range(0, 3);
         1:       return (256 * $urandom_range(0, 3) + $urandom_range(0, 4) + 1022) % 1024;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   // random rays in bursts over a run of random maps
   task automatic test_random_rays;
      int sent, burst, a, v, i, next_map;
      logic [grc_pkg::MAP_W-1:0] m;
      grc_pkg::req_type r;
      sent = 0;
      next_map = 0;
      while (sent < RANDOM_RAYS) begin
         if (sent >= next_map) begin
            next_map = next_map + 380;
            m = {$urandom, $urandom};
            case ($urandom_range(0, 3))
               0: m = m & {$urandom, $urandom};
               1: m = m | {$urandom, $urandom};
               2: m = m & {$urandom, $urandom} & {$urandom, $urandom};
               default: ;
            endcase
            write_map(m);
         end
         burst = $urandom_range(1, 12);
         for (i = 0; i < burst && sent < RANDOM_RAYS; i++) begin
            a = pick_angle();
            case ($urandom_range(0, 3))
               0:       v = $urandom_range(0, 1023);
               default: v = (a + $urandom_range(0, 340) + 854) % 1024;
            endcase
            r.pos_x      = grc_pkg::POS_W'($urandom_range(0, 131071));
            r.pos_y      = grc_pkg::POS_W'($urandom_range(0, 131071));
            if ($urandom_range(0, 7) == 0) begin
               r.pos_y = grc_pkg::POS_W'(grc_pkg::TILE_Q * $urandom_range(0, 7));
            end
            r.ray_angle  = a[grc_pkg::ANG_W-1:0];
            r.view_angle = v[grc_pkg::ANG_W-1:0];
            send_ray(r);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      cycles    = 0;
      errors    = 0;
      rays_sent = 0;
      walls_seen = 0;
      vertical_seen = 0;
      maps_written = 0;
      stimulus_done = 0;
      map_copy  = grc_pkg::MAP_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_axis_angles();
      test_edges();
      test_behind_viewer();
      test_map_extremes();
      write_map(grc_pkg::MAP_RESET);
      test_random_rays();

      drain();
      repeat (250) @(posedge clock);
      $display("%0d rays cast over %0d map writes: %0d hit a wall, %0d on vertical lines",
               rays_sent, maps_written, walls_seen, vertical_seen);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
